/* src/rgst_pkg.sv */
package rgst_pkg;

    // Array and table sizing.
    localparam int MAX_ELEMENTS = 1024;
    localparam int TABLE_LEVELS = 11;
    localparam int VALUE_WIDTH  = 31;

    localparam int IDX_W     = $clog2(MAX_ELEMENTS);
    localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
    localparam int LVL_W     = $clog2(TABLE_LEVELS + 1);
    localparam int SHF_W     = $clog2(VALUE_WIDTH + 1);
    localparam int MEM_AW    = LVL_W + IDX_W;
    localparam int MEM_DEPTH = TABLE_LEVELS << IDX_W;
    localparam int PORT_IDX_W = 10;
    localparam int SPAN_W     = 10;
    localparam int WIDE_W     = 18;

    // Operation and status codes.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_QUERY   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BCHK,
        S_QADR,
        S_RDA,
        S_RDB,
        S_LDB,
        S_GCD,
        S_USE,
        S_S1CHK,
        S_S2CHK,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_BUILD,
        PH_G,
        PH_S1,
        PH_S2
    } phase_t;

    // Position of the highest set bit; zero for an input of zero or one.
    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
        logic [LVL_W-1:0] n;
        n = '0;
        for (int b = 0; b < CNT_W; b++)
        begin
            if (v[b])
            begin
                n = LVL_W'(b);
            end
        end
        return n;
    endfunction

endpackage

/* src/range_gcd_sparse_table.sv */
// Range GCD engine over a sparse table.
// Input channel (in_valid / in_stall): op selects a load or a query. A load
// stores value as the next array element; a load with last_element set builds
// the table, one GCD per table entry. A load after a build starts a new
// array. Loads give no result.
// A query gives one result on the output channel (out_valid / out_stall):
// range_gcd, span and status. A query costs one range GCD plus two binary
// searches, so at most 1 + 2*ceil(log2(count)) sub-queries of two table reads
// and one binary GCD; each GCD step is one compare-subtract or shift. The
// single GCD unit and the single table read port set the cost of a query.
// in_stall is high whenever the sequencer is busy. A finished result sits in
// the output register while the receiver stalls; loads are still taken, and
// the next query is still computed, but its result waits for the output register to free up.
// Reset clears the element count and the table-ready flag; the table memory
// itself is not cleared.
module range_gcd_sparse_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic [rgst_pkg::VALUE_WIDTH-1:0]     value,
    input  logic                                 last_element,
    input  logic [rgst_pkg::PORT_IDX_W-1:0]      left_index,
    input  logic [rgst_pkg::PORT_IDX_W-1:0]      right_index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rgst_pkg::VALUE_WIDTH-1:0]     range_gcd,
    output logic [rgst_pkg::SPAN_W-1:0]          span,
    output logic                                 status
);
    import rgst_pkg::*;

    // Control registers.
    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ready_reg, ready_next;
    logic                   out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [LVL_W-1:0]       lvl_reg, lvl_next;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [IDX_W-1:0]       l_reg, l_next;
    logic [IDX_W-1:0]       r_reg, r_next;
    logic [IDX_W-1:0]       lo_reg, lo_next;
    logic [IDX_W-1:0]       hi_reg, hi_next;
    logic [IDX_W-1:0]       mid_reg, mid_next;
    logic [IDX_W-1:0]       qhi_reg, qhi_next;
    logic [IDX_W-1:0]       first_reg, first_next;
    logic [MEM_AW-1:0]      addr_a_reg, addr_a_next;
    logic [MEM_AW-1:0]      addr_b_reg, addr_b_next;
    logic [VALUE_WIDTH-1:0] ga_reg, ga_next;
    logic [VALUE_WIDTH-1:0] gb_reg, gb_next;
    logic [SHF_W-1:0]       gk_reg, gk_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic [VALUE_WIDTH-1:0] g_reg, g_next;
    logic [VALUE_WIDTH-1:0] pend_gcd_reg, pend_gcd_next;
    logic [SPAN_W-1:0]      pend_span_reg, pend_span_next;
    logic                   pend_err_reg, pend_err_next;
    logic [VALUE_WIDTH-1:0] out_gcd_reg, out_gcd_next;
    logic [SPAN_W-1:0]      out_span_reg, out_span_next;
    logic                   out_err_reg, out_err_next;

    // Table memory.
    logic [VALUE_WIDTH-1:0] mem [0:MEM_DEPTH-1];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [MEM_AW-1:0]      mem_ra;
    logic [MEM_AW-1:0]      mem_wa;
    logic [VALUE_WIDTH-1:0] mem_wd;
    logic                   mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_BUILD;
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        lvl_reg       <= lvl_next;
        i_reg         <= i_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        qhi_reg       <= qhi_next;
        first_reg     <= first_next;
        addr_a_reg    <= addr_a_next;
        addr_b_reg    <= addr_b_next;
        ga_reg        <= ga_next;
        gb_reg        <= gb_next;
        gk_reg        <= gk_next;
        res_reg       <= res_next;
        g_reg         <= g_next;
        pend_gcd_reg  <= pend_gcd_next;
        pend_span_reg <= pend_span_next;
        pend_err_reg  <= pend_err_next;
        out_gcd_reg   <= out_gcd_next;
        out_span_reg  <= out_span_next;
        out_err_reg   <= out_err_next;
    end

    // Sequencer: loads, table build, sub-queries, binary searches and GCD steps.
    always_comb
    begin
        logic [CNT_W-1:0]   cnt_eff;
        logic [CNT_W-1:0]   cnt_new;
        logic [LVL_W-1:0]   levels;
        logic [CNT_W:0]     run;
        logic [CNT_W:0]     half;
        logic [CNT_W-1:0]   qlen;
        logic [LVL_W-1:0]   qk;
        logic [CNT_W-1:0]   qb;
        logic [IDX_W:0]     msum;
        logic [WIDE_W-1:0]  l_wide;
        logic [WIDE_W-1:0]  r_wide;
        logic [WIDE_W-1:0]  c_wide;

        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg;
        lvl_next       = lvl_reg;
        i_next         = i_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        qhi_next       = qhi_reg;
        first_next     = first_reg;
        addr_a_next    = addr_a_reg;
        addr_b_next    = addr_b_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        gk_next        = gk_reg;
        res_next       = res_reg;
        g_next         = g_reg;
        pend_gcd_next  = pend_gcd_reg;
        pend_span_next = pend_span_reg;
        pend_err_next  = pend_err_reg;
        out_gcd_next   = out_gcd_reg;
        out_span_next  = out_span_reg;
        out_err_next   = out_err_reg;
        mem_ra         = addr_a_reg;
        mem_wa         = {lvl_reg, i_reg};
        mem_wd         = res_reg;
        mem_we         = 1'b0;

        cnt_eff = ready_reg ? '0 : count_reg;
        cnt_new = cnt_eff;
        levels  = floor_log2(count_reg) + LVL_W'(1);
        if (levels > LVL_W'(TABLE_LEVELS))
        begin
            levels = LVL_W'(TABLE_LEVELS);
        end
        run  = (CNT_W+1)'(1) << lvl_reg;
        half = run >> 1;
        qlen = CNT_W'(qhi_reg) - CNT_W'(l_reg) + CNT_W'(1);
        qk   = floor_log2(qlen);
        if (qk > LVL_W'(TABLE_LEVELS - 1))
        begin
            qk = LVL_W'(TABLE_LEVELS - 1);
        end
        qb     = CNT_W'(qhi_reg) - (CNT_W'(1) << qk) + CNT_W'(1);
        msum   = '0;
        l_wide = WIDE_W'(left_index);
        r_wide = WIDE_W'(right_index);
        c_wide = WIDE_W'(count_reg);

        // The output register frees up once the receiver takes the transfer.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_LOAD)
                    begin
                        ready_next = 1'b0;
                        if (cnt_eff < CNT_W'(MAX_ELEMENTS))
                        begin
                            mem_we  = 1'b1;
                            mem_wa  = {LVL_W'(0), cnt_eff[IDX_W-1:0]};
                            mem_wd  = value;
                            cnt_new = cnt_eff + CNT_W'(1);
                        end
                        count_next = cnt_new;
                        if (last_element && cnt_new != '0)
                        begin
                            lvl_next   = LVL_W'(1);
                            i_next     = '0;
                            state_next = S_BCHK;
                        end
                    end
                    else if (!ready_reg || l_wide > r_wide || r_wide >= c_wide)
                    begin
                        pend_gcd_next  = '0;
                        pend_span_next = '0;
                        pend_err_next  = STATUS_ERR;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        l_next     = left_index[IDX_W-1:0];
                        r_next     = right_index[IDX_W-1:0];
                        qhi_next   = right_index[IDX_W-1:0];
                        phase_next = PH_G;
                        state_next = S_QADR;
                    end
                end
            end

            // One table level at a time, one entry per GCD.
            S_BCHK:
            begin
                if (lvl_reg >= levels)
                begin
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if ((CNT_W+1)'(i_reg) + run <= (CNT_W+1)'(count_reg))
                begin
                    addr_a_next = {lvl_reg - LVL_W'(1), i_reg};
                    addr_b_next = {lvl_reg - LVL_W'(1), IDX_W'((CNT_W+1)'(i_reg) + half)};
                    phase_next  = PH_BUILD;
                    state_next  = S_RDA;
                end
                else
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                    i_next   = '0;
                end
            end

            // Table addresses of a sub-query from left to qhi.
            S_QADR:
            begin
                addr_a_next = {qk, l_reg};
                addr_b_next = {qk, qb[IDX_W-1:0]};
                state_next  = S_RDA;
            end

            S_RDA:
            begin
                mem_ra     = addr_a_reg;
                state_next = S_RDB;
            end

            S_RDB:
            begin
                mem_ra     = addr_b_reg;
                ga_next    = rd_data_reg;
                state_next = S_LDB;
            end

            S_LDB:
            begin
                gb_next    = rd_data_reg;
                gk_next    = '0;
                state_next = S_GCD;
            end

            // Binary GCD, one shift or compare-subtract per cycle.
            S_GCD:
            begin
                priority if (ga_reg == '0)
                begin
                    res_next   = gb_reg << gk_reg;
                    state_next = S_USE;
                end
                else if (gb_reg == '0)
                begin
                    res_next   = ga_reg << gk_reg;
                    state_next = S_USE;
                end
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    gk_next = gk_reg + SHF_W'(1);
                end
                else if (!ga_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                end
                else if (!gb_reg[0])
                begin
                    gb_next = gb_reg >> 1;
                end
                else if (ga_reg >= gb_reg)
                begin
                    ga_next = ga_reg - gb_reg;
                end
                else
                begin
                    gb_next = gb_reg - ga_reg;
                end
            end

            S_USE:
            begin
                unique case (phase_reg)
                    PH_BUILD:
                    begin
                        mem_we     = 1'b1;
                        mem_wa     = {lvl_reg, i_reg};
                        mem_wd     = res_reg;
                        i_next     = i_reg + IDX_W'(1);
                        state_next = S_BCHK;
                    end
                    PH_G:
                    begin
                        g_next     = res_reg;
                        lo_next    = l_reg;
                        hi_next    = r_reg;
                        state_next = S_S1CHK;
                    end
                    PH_S1:
                    begin
                        if (res_reg > g_reg)
                        begin
                            lo_next = mid_reg + IDX_W'(1);
                        end
                        else
                        begin
                            hi_next = mid_reg;
                        end
                        state_next = S_S1CHK;
                    end
                    PH_S2:
                    begin
                        if (res_reg < g_reg)
                        begin
                            hi_next = mid_reg - IDX_W'(1);
                        end
                        else
                        begin
                            lo_next = mid_reg;
                        end
                        state_next = S_S2CHK;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // Search for the first right end that reaches the range GCD.
            S_S1CHK:
            begin
                if (lo_reg < hi_reg)
                begin
                    msum       = (IDX_W+1)'(lo_reg) + (IDX_W+1)'(hi_reg);
                    mid_next   = msum[IDX_W:1];
                    qhi_next   = msum[IDX_W:1];
                    phase_next = PH_S1;
                    state_next = S_QADR;
                end
                else
                begin
                    first_next = lo_reg;
                    lo_next    = r_reg;
                    hi_next    = IDX_W'(count_reg - CNT_W'(1));
                    state_next = S_S2CHK;
                end
            end

            // Search for the last right end that keeps the range GCD.
            S_S2CHK:
            begin
                if (lo_reg < hi_reg)
                begin
                    msum       = (IDX_W+1)'(lo_reg) + (IDX_W+1)'(hi_reg) + (IDX_W+1)'(1);
                    mid_next   = msum[IDX_W:1];
                    qhi_next   = msum[IDX_W:1];
                    phase_next = PH_S2;
                    state_next = S_QADR;
                end
                else
                begin
                    pend_gcd_next  = g_reg;
                    pend_span_next = SPAN_W'(hi_reg - first_reg);
                    pend_err_next  = STATUS_OK;
                    state_next     = S_OUT;
                end
            end

            // Hand the result to the output register once it is free.
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_gcd_next   = pend_gcd_reg;
                    out_span_next  = pend_span_reg;
                    out_err_next   = pend_err_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign range_gcd = out_gcd_reg;
    assign span      = out_span_reg;
    assign status    = out_err_reg;

endmodule

/* src/rgst_checker.sv */
module rgst_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             op,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [rgst_pkg::VALUE_WIDTH-1:0] range_gcd,
    input logic [rgst_pkg::SPAN_W-1:0]      span,
    input logic                             status
);
    import rgst_pkg::*;

    // A stalled result stays on offer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // An error result carries zero fields.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_ERR |-> range_gcd == '0 && span == '0)
        else $error("error result with nonzero fields");

    // A load transfer never creates a result.
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_LOAD && !out_valid |=> !out_valid)
        else $error("result after a load");

    // A query keeps the block busy in the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_QUERY |=> in_stall)
        else $error("input taken during a query");

endmodule

bind range_gcd_sparse_table rgst_checker u_rgst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .range_gcd (range_gcd),
    .span      (span),
    .status    (status)
);

/* bench/range_gcd_sparse_table_test.sv */
module range_gcd_sparse_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rgst_pkg::*;

    // One input transfer, with an optional typed-in answer.
    typedef struct packed {
        logic                   op;
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
        logic [PORT_IDX_W-1:0]  left;
        logic [PORT_IDX_W-1:0]  right;
        logic                   typed;
        logic [VALUE_WIDTH-1:0] t_gcd;
        logic [SPAN_W-1:0]      t_span;
        logic                   t_status;
    } request_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] gcd;
        logic [SPAN_W-1:0]      span;
        logic                   status;
    } answer_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   op;
    logic [VALUE_WIDTH-1:0] value;
    logic                   last_element;
    logic [PORT_IDX_W-1:0]  left_index;
    logic [PORT_IDX_W-1:0]  right_index;
    logic                   out_valid;
    logic                   out_stall;
    logic [VALUE_WIDTH-1:0] range_gcd;
    logic [SPAN_W-1:0]      span;
    logic                   status;

    request_t               requests[$];
    answer_t                answers_due[$];
    logic [VALUE_WIDTH-1:0] loaded_array[$];
    bit                     array_built;
    int                     error_count;
    int                     answers_seen;

    range_gcd_sparse_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .value        (value),
        .last_element (last_element),
        .left_index   (left_index),
        .right_index  (right_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .range_gcd    (range_gcd),
        .span         (span),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(64'd60_000_000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [VALUE_WIDTH-1:0] euclid(input logic [VALUE_WIDTH-1:0] a,
                                                      input logic [VALUE_WIDTH-1:0] b);
        logic [VALUE_WIDTH-1:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // GCD of the loaded elements lo..hi, folded left to right.
    function automatic logic [VALUE_WIDTH-1:0] gcd_over(input int lo, input int hi);
        logic [VALUE_WIDTH-1:0] g;
        g = '0;
        for (int i = lo; i <= hi; i++)
        begin
            g = euclid(g, loaded_array[i]);
        end
        return g;
    endfunction

    function automatic request_t load_req(input logic [VALUE_WIDTH-1:0] v, input logic lst);
        request_t q;
        q = '0;
        q.op = OP_LOAD;
        q.value = v;
        q.last = lst;
        return q;
    endfunction

    function automatic request_t query_req(input int l, input int r);
        request_t q;
        q = '0;
        q.op = OP_QUERY;
        q.left = PORT_IDX_W'(l);
        q.right = PORT_IDX_W'(r);
        q.value = VALUE_WIDTH'($urandom);
        return q;
    endfunction

    // Track the array on each accepted transfer and queue the answer a query must give.
    task automatic track_transfer(input request_t q);
        answer_t a;
        int l, r, lo, hi, mid, first_end, n;
        logic [VALUE_WIDTH-1:0] g;
        if (q.op == OP_LOAD)
        begin
            if (array_built)
            begin
                array_built = 1'b0;
                loaded_array.delete();
            end
            if (loaded_array.size() < MAX_ELEMENTS)
            begin
                loaded_array.push_back(q.value);
            end
            if (q.last && loaded_array.size() > 0)
            begin
                array_built = 1'b1;
            end
        end
        else
        begin
            l = q.left;
            r = q.right;
            n = loaded_array.size();
            if (!array_built || l > r || r >= n)
            begin
                a = '{gcd: '0, span: '0, status: STATUS_ERR};
            end
            else
            begin
                g = gcd_over(l, r);
                // First end with the full-range GCD.
                lo = l;
                hi = r;
                while (lo < hi)
                begin
                    mid = (lo + hi) >> 1;
                    if (gcd_over(l, mid) > g)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                first_end = lo;
                // Last end that still keeps that GCD.
                lo = r;
                hi = n - 1;
                while (lo < hi)
                begin
                    mid = (lo + hi + 1) >> 1;
                    if (gcd_over(l, mid) < g)
                        hi = mid - 1;
                    else
                        lo = mid;
                end
                a = '{gcd: g, span: SPAN_W'(hi - first_end), status: STATUS_OK};
            end
            if (q.typed)
            begin
                a = '{gcd: q.t_gcd, span: q.t_span, status: q.t_status};
            end
            answers_due.push_back(a);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Check every result transfer against the oldest queued answer.
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && out_valid && !out_stall)
        begin
            answers_seen++;
            if (answers_due.size() == 0)
            begin
                report_mismatch("unexpected result, gcd", range_gcd, 0);
            end
            else
            begin
                a = answers_due.pop_front();
                if (range_gcd !== a.gcd)
                    report_mismatch("range_gcd", range_gcd, a.gcd);
                if (span !== a.span)
                    report_mismatch("span", span, a.span);
                if (status !== a.status)
                    report_mismatch("status", status, a.status);
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a quiet window.
    initial
    begin
        int cycle_count;
        int hold_left;
        bit held_once;
        cycle_count = 0;
        hold_left = 0;
        held_once = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!held_once && answers_seen >= 20)
            begin
                held_once = 1;
                hold_left = 40000;
                out_stall <= 1'b1;
            end
            else if (cycle_count >= 20000 && cycle_count < 80000)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 14);
        end
    end

    // Stimulus: directed rows, then random arrays and queries.
    initial
    begin
        request_t directed_rows[20];
        request_t cur;
        int n, nq, random_items, next_idx, taken, base, l, r;
        logic [VALUE_WIDTH-1:0] factor;

        in_valid = 1'b0;
        op = OP_LOAD;
        value = '0;
        last_element = 1'b0;
        left_index = '0;
        right_index = '0;
        error_count = 0;
        answers_seen = 0;
        array_built = 1'b0;

        directed_rows = '{
            '{OP_QUERY, 31'd0, 1'b0, 10'd0, 10'd0, 1'b1, 31'd0, 10'd0, STATUS_ERR},
            '{OP_LOAD, 31'd12, 1'b0, 10'd0, 10'd0, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_LOAD, 31'd18, 1'b0, 10'd0, 10'd0, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_LOAD, 31'd30, 1'b0, 10'd0, 10'd0, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_LOAD, 31'd0, 1'b0, 10'd0, 10'd0, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_LOAD, 31'd0, 1'b0, 10'd0, 10'd0, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_LOAD, 31'd42, 1'b1, 10'd0, 10'd0, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_QUERY, 31'd0, 1'b0, 10'd0, 10'd5, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_QUERY, 31'd0, 1'b0, 10'd3, 10'd4, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_QUERY, 31'd0, 1'b0, 10'd0, 10'd0, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_QUERY, 31'd0, 1'b0, 10'd5, 10'd5, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_QUERY, 31'd0, 1'b0, 10'd2, 10'd4, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_QUERY, 31'd0, 1'b0, 10'd2, 10'd1, 1'b1, 31'd0, 10'd0, STATUS_ERR},
            '{OP_QUERY, 31'd0, 1'b0, 10'd0, 10'd6, 1'b1, 31'd0, 10'd0, STATUS_ERR},
            '{OP_QUERY, 31'd0, 1'b0, 10'd1023, 10'd1023, 1'b1, 31'd0, 10'd0, STATUS_ERR},
            '{OP_QUERY, 31'd0, 1'b0, 10'd0, 10'd1023, 1'b1, 31'd0, 10'd0, STATUS_ERR},
            '{OP_LOAD, 31'h7FFFFFFF, 1'b1, 10'd0, 10'd0, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_QUERY, 31'd0, 1'b0, 10'd0, 10'd0, 1'b1, 31'h7FFFFFFF, 10'd0, STATUS_OK},
            '{OP_LOAD, 31'd1, 1'b0, 10'd0, 10'd0, 1'b0, 31'd0, 10'd0, STATUS_OK},
            '{OP_QUERY, 31'd0, 1'b0, 10'd0, 10'd0, 1'b1, 31'd0, 10'd0, STATUS_ERR}
        };
        foreach (directed_rows[i])
        begin
            requests.push_back(directed_rows[i]);
        end

        // Random arrays, each followed by a burst of queries.
        random_items = 0;
        while (random_items < 130)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
            factor = VALUE_WIDTH'($urandom_range(1, 5000));
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0: cur = load_req('0, i == n - 1);
                    1, 2, 3: cur = load_req(VALUE_WIDTH'($urandom), i == n - 1);
                    default: cur = load_req(factor * VALUE_WIDTH'($urandom_range(1, 60000)),
                                            i == n - 1);
                endcase
                requests.push_back(cur);
                random_items++;
                // Stray query while the array is still loading.
                if (i < n - 1 && $urandom_range(0, 19) == 0)
                begin
                    requests.push_back(query_req($urandom_range(0, i), $urandom_range(0, i)));
                    random_items++;
                end
            end
            nq = $urandom_range(3, 8);
            for (int i = 0; i < nq; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    requests.push_back(query_req($urandom_range(0, 1023),
                                                 $urandom_range(0, 1023)));
                end
                else
                begin
                    l = $urandom_range(0, n - 1);
                    requests.push_back(query_req(l, $urandom_range(l, n - 1)));
                end
                random_items++;
            end
        end
        base = 20;

        wait (rst_n === 1'b1);
        next_idx = 0;
        taken = 0;
        cur = '0;
        while (taken < requests.size())
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                track_transfer(cur);
                taken++;
            end
            if (!in_valid || !in_stall)
            begin
                // Offer the next transfer unless this cycle idles; a window of steady flow.
                if (next_idx < requests.size() &&
                    ((next_idx >= base + 40 && next_idx < base + 100) ||
                     $urandom_range(0, 99) >= 14))
                begin
                    cur = requests[next_idx];
                    next_idx++;
                    op <= cur.op;
                    value <= cur.value;
                    last_element <= cur.last;
                    left_index <= cur.left;
                    right_index <= cur.right;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end

        wait (answers_due.size() == 0);
        repeat (3500) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
